>>> hdl/s2d_pkg.sv
package s2d_pkg;

    // Field and internal types
    typedef logic [31:0] t_mag;
    typedef logic [3:0]  t_digit;
    typedef logic [7:0]  t_char;
    typedef logic [4:0]  t_len;

    // Quotient and remainder of one divide-by-ten step
    typedef struct packed {
        t_mag   quot;
        t_digit rem;
    } t_div_res;

    // ASCII codes
    localparam t_char C_CHAR_MINUS = 8'd45;
    localparam t_char C_CHAR_ZERO  = 8'd48;

    // Reciprocal of ten: q = (x * C_RECIP_TEN) >> C_RECIP_SHIFT, exact for 32-bit x
    localparam t_mag C_RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int   C_RECIP_SHIFT = 35;
    localparam int   C_TEN         = 10;

    // Text limits
    localparam int   C_DIGITS_MAX   = 10;
    localparam t_len C_BUFFER_CHARS = 5'd16;
    localparam t_len C_LEN_RESET    = 5'd11;
    localparam t_len C_LEN_MIN      = 5'd1;

endpackage

>>> hdl/s2d_div10.sv
module s2d_div10 (
    input  s2d_pkg::t_mag     i_mag,
    output s2d_pkg::t_div_res o_res
);

    logic [63:0]    prod;
    s2d_pkg::t_mag  quot;
    s2d_pkg::t_mag  quot_x10;
    s2d_pkg::t_mag  rem_full;

    // Multiply by the reciprocal and keep the integer part
    assign prod     = {32'd0, i_mag} * {32'd0, s2d_pkg::C_RECIP_TEN};
    assign quot     = {3'd0, prod[63:s2d_pkg::C_RECIP_SHIFT]};

    // Remainder from the quotient times ten (shift and add)
    assign quot_x10 = (quot << 3) + (quot << 1);
    assign rem_full = i_mag - quot_x10;

    assign o_res.quot = quot;
    assign o_res.rem  = rem_full[3:0];

endmodule

>>> hdl/signed_int_to_decimal_ascii.sv
// Converts one signed 32-bit integer per request into its decimal ASCII text, sent one
// character per output request: '-' first for a negative value, then the digits most
// significant first, '0' for zero, and o_last on the final character. The most negative
// value prints as -2147483648. At most max_length characters go out (0 acts as 1, values
// above 16 act as 16); the rest are dropped. One shared divide-by-ten unit (a 32x32
// reciprocal multiply) peels off one digit per cycle, then the sequencer emits one
// character per cycle while the output is not stalled, and o_stall stays high until its
// last character is in the output register.
module signed_int_to_decimal_ascii (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input requests
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [31:0]  i_number,
    // output requests
    output logic                o_valid,
    input  logic                i_stall,
    output logic [7:0]          o_character,
    output logic                o_last,
    // configuration
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [4:0]          i_cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]             r_state, n_state;
    s2d_pkg::t_len          r_max_len;
    logic                   r_neg, n_neg;
    s2d_pkg::t_mag          r_mag, n_mag;
    s2d_pkg::t_digit        r_dig [s2d_pkg::C_DIGITS_MAX];
    s2d_pkg::t_digit        n_dig [s2d_pkg::C_DIGITS_MAX];
    logic [3:0]             r_nd, n_nd;
    logic [3:0]             r_ptr, n_ptr;
    logic [3:0]             r_cnt, n_cnt;
    logic                   r_out_valid, n_out_valid;
    s2d_pkg::t_char         r_char, n_char;
    logic                   r_last, n_last;

    s2d_pkg::t_div_res      div_res;
    s2d_pkg::t_len          eff_len;
    s2d_pkg::t_len          text_len;
    s2d_pkg::t_len          emit_len;
    logic                   in_accept;
    logic                   out_free;
    logic                   is_last;

    // Shared divide-by-ten unit
    s2d_div10 u_div10 (
        .i_mag (r_mag),
        .o_res (div_res)
    );

    assign in_accept = i_valid && (r_state == S_IDLE);
    assign out_free  = !r_out_valid || !i_stall;

    // Clamp the length limit and find how many characters go out
    always_comb begin
        if (r_max_len == 5'd0) begin
            eff_len = s2d_pkg::C_LEN_MIN;
        end else if (r_max_len > s2d_pkg::C_BUFFER_CHARS) begin
            eff_len = s2d_pkg::C_BUFFER_CHARS;
        end else begin
            eff_len = r_max_len;
        end
        text_len = {4'd0, r_neg} + {1'b0, r_nd};
        emit_len = (text_len < eff_len) ? text_len : eff_len;
        is_last  = ({1'b0, r_cnt} == (emit_len - 5'd1));
    end

    // Sequencer: take the number, extract digits, emit characters
    always_comb begin
        n_state     = r_state;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_dig       = r_dig;
        n_nd        = r_nd;
        n_ptr       = r_ptr;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_stall;
        n_char      = r_char;
        n_last      = r_last;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_neg   = i_number[31];
                    n_mag   = i_number[31] ? (32'd0 - s2d_pkg::t_mag'(i_number))
                                           : s2d_pkg::t_mag'(i_number);
                    n_nd    = 4'd0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_dig[r_nd] = div_res.rem;
                n_nd        = r_nd + 4'd1;
                n_mag       = div_res.quot;
                if (div_res.quot == '0) begin
                    n_ptr   = r_nd;
                    n_cnt   = 4'd0;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_last      = is_last;
                    if (r_neg && (r_cnt == 4'd0)) begin
                        n_char = s2d_pkg::C_CHAR_MINUS;
                    end else begin
                        n_char = s2d_pkg::C_CHAR_ZERO + {4'd0, r_dig[r_ptr]};
                        n_ptr  = r_ptr - 4'd1;
                    end
                    n_cnt = r_cnt + 4'd1;
                    if (is_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_max_len   <= s2d_pkg::C_LEN_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_max_len <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_neg  <= n_neg;
        r_mag  <= n_mag;
        r_dig  <= n_dig;
        r_nd   <= n_nd;
        r_ptr  <= n_ptr;
        r_cnt  <= n_cnt;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_character = r_char;
    assign o_last      = r_last;
    assign o_cfg_ready = 1'b1;

endmodule

>>> hdl/s2d_checker.sv
module s2d_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_valid,
    input logic         o_stall,
    input logic         o_valid,
    input logic         i_stall,
    input logic [7:0]   o_character,
    input logic         o_last,
    input logic         i_cfg_valid,
    input logic         o_cfg_ready
);

    // Hold a stalled output request
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && o_valid && i_stall) |=>
            (o_valid && $stable(o_character) && $stable(o_last)))
        else $error("stalled output request changed");

    // Emit only a minus sign or a decimal digit
    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_character == 8'd45 ||
                     (o_character >= 8'd48 && o_character <= 8'd57)))
        else $error("character outside minus and digits");

    // Stall the input while a number is being converted
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_valid && !o_stall) |=> o_stall)
        else $error("input not stalled after a request");

    // Keep the configuration port always open
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_cfg_valid) |-> o_cfg_ready)
        else $error("configuration write refused");

    // A minus sign is never directly followed by another minus sign
    a_zero_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && o_valid && !i_stall && o_character == 8'd45) |=>
            !(o_valid && o_character == 8'd45))
        else $error("two minus signs in a row");

endmodule

bind signed_int_to_decimal_ascii s2d_checker u_s2d_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_character (o_character),
    .o_last      (o_last),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready)
);

>>> tb/testbench.sv
module testbench;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 30;
    localparam int REPORT_MAX = 10;

    // One character of the decimal text together with its end flag
    typedef struct packed {
        s2d_pkg::t_char code;
        logic           last;
    } t_char_rec;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [31:0] i_number = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [7:0]         o_character;
    logic               o_last;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [4:0]         i_cfg_data = '0;

    // Numbers waiting to be offered, and characters expected back in order
    logic signed [31:0] numbers_to_send[$];
    t_char_rec          expected_chars[$];

    // Length limit as the block should currently hold it
    s2d_pkg::t_len limit_reg = s2d_pkg::C_LEN_RESET;

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_request = 1'b0;
    int  hold_left = 0;
    bit  number_taken = 1'b0;
    int  cycle_count = 0;
    int  error_count = 0;
    int  numbers_done = 0;
    int  chars_done = 0;
    int  truncated_numbers = 0;
    int  cfg_writes = 0;

    signed_int_to_decimal_ascii dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_number    (i_number),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_character (o_character),
        .o_last      (o_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic void note_error(input string msg);
        error_count++;
        if (error_count <= REPORT_MAX) begin
            $display("[%0d] ERROR: %s", cycle_count, msg);
        end
    endfunction

    // Build the decimal text of one number, cut it to the length limit and queue it
    function automatic void predict_text(input logic signed [31:0] num);
        logic [31:0]    mag;
        s2d_pkg::t_char digits_rev [s2d_pkg::C_DIGITS_MAX];
        s2d_pkg::t_char text [s2d_pkg::C_DIGITS_MAX + 1];
        t_char_rec      rec;
        int             nd;
        int             n;
        int             lim;
        int             k;
        n = 0;
        nd = 0;
        mag = num[31] ? (32'd0 - 32'(num)) : 32'(num);
        if (num[31]) begin
            text[n] = s2d_pkg::C_CHAR_MINUS;
            n++;
        end
        // Peel off digits least significant first
        do begin
            digits_rev[nd] = s2d_pkg::C_CHAR_ZERO + 8'(mag % s2d_pkg::C_TEN);
            mag = mag / s2d_pkg::C_TEN;
            nd++;
        end while (mag != 0 && nd < s2d_pkg::C_DIGITS_MAX);
        while (nd > 0) begin
            nd--;
            text[n] = digits_rev[nd];
            n++;
        end
        // Clamp the limit: zero acts as one, anything past the buffer as the buffer
        lim = (limit_reg == 0) ? int'(s2d_pkg::C_LEN_MIN) : int'(limit_reg);
        if (lim > int'(s2d_pkg::C_BUFFER_CHARS)) lim = int'(s2d_pkg::C_BUFFER_CHARS);
        k = (n < lim) ? n : lim;
        if (k < n) truncated_numbers++;
        for (int i = 0; i < k; i++) begin
            rec.code = text[i];
            rec.last = (i == k - 1);
            expected_chars.push_back(rec);
        end
    endfunction

    // Spread numbers over every digit count, both signs and both ends of the range
    function automatic logic signed [31:0] pick_number();
        logic signed [31:0] n;
        logic [31:0]        p;
        case ($urandom_range(0, 4))
            0: n = $urandom;
            1: n = $urandom_range(0, 9);
            2: n = $urandom_range(0, 999999);
            3: n = $urandom_range(0, 1) ? 32'sh8000_0000 + $urandom_range(0, 20)
                                        : 32'sh7FFF_FFFF - $urandom_range(0, 20);
            default: begin
                p = 1;
                repeat ($urandom_range(0, 9)) p = p * s2d_pkg::C_TEN;
                n = p + $urandom_range(0, 2) - 1;
            end
        endcase
        if ($urandom_range(0, 1) && n != 32'sh8000_0000) n = -n;
        return n;
    endfunction

    // Offer the next request once the current one is taken; hold a stalled one
    always @(negedge i_clk) begin : number_driver
        if (!i_valid || number_taken) begin
            if (i_rst_n && numbers_to_send.size() != 0 &&
                $urandom_range(0, 99) >= send_idle_pct) begin
                i_valid  <= 1'b1;
                i_number <= numbers_to_send.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Stall the output at random, or for a long stretch on request
    always @(negedge i_clk) begin : char_sink
        if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Sample handshakes, predict on accepted numbers, check accepted characters
    always @(posedge i_clk) begin : monitor
        t_char_rec want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("signed_int_to_decimal_ascii: mismatch");
            $finish;
        end else begin
            number_taken <= i_rst_n && i_valid && !o_stall;
            if (i_rst_n) begin
                if (i_cfg_valid && o_cfg_ready) begin
                    limit_reg = i_cfg_data;
                    cfg_writes++;
                end
                if (i_valid && !o_stall) begin
                    predict_text(i_number);
                    numbers_done++;
                end
                if (o_valid && !i_stall) begin
                    chars_done++;
                    if (expected_chars.size() == 0) begin
                        note_error($sformatf("unexpected character %0d last %0b",
                                             o_character, o_last));
                    end else begin
                        want = expected_chars.pop_front();
                        if (o_character !== want.code) begin
                            note_error($sformatf("character: expected %0d got %0d",
                                                 want.code, o_character));
                        end
                        if (o_last !== want.last) begin
                            note_error($sformatf("last flag on %0d: expected %0b got %0b",
                                                 want.code, want.last, o_last));
                        end
                    end
                end
            end
        end
    end

    // Wait until every queued number is taken and every character has come back
    task automatic wait_drained();
        do begin
            @(posedge i_clk);
            #1;
        end while (numbers_to_send.size() != 0 || i_valid || expected_chars.size() != 0);
    endtask

    task automatic write_limit(input s2d_pkg::t_len value);
        int writes_before;
        writes_before = cfg_writes;
        @(negedge i_clk);
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        wait (cfg_writes != writes_before);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // One setting of the limit with its own idle mix and a batch of random numbers
    task automatic run_batch(input s2d_pkg::t_len value, input int send_pct,
                             input int recv_pct, input int count, input bit long_hold);
        wait_drained();
        write_limit(value);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count) numbers_to_send.push_back(pick_number());
        if (long_hold) hold_request = 1'b1;
    endtask

    initial begin
        logic signed [31:0] directed [] = '{
            32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99, -32'sd100,
            32'sd2147483647, 32'sh8000_0000, -32'sd2147483647, 32'sd1000000000,
            -32'sd999999999, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sd123456789,
            -32'sd7, 32'sd4294967
        };
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed numbers under the limit left by reset
        foreach (directed[i]) numbers_to_send.push_back(directed[i]);

        // Limit extremes and idle mixes, with the long output hold in the middle
        run_batch(5'd0,  0,  0,  39, 1'b0);
        run_batch(5'd1,  45, 0,  39, 1'b0);
        run_batch(5'd31, 0,  45, 39, 1'b0);
        run_batch(5'd16, 36, 36, 39, 1'b0);
        run_batch(5'd17, 0,  0,  39, 1'b1);
        run_batch(5'd5,  45, 0,  39, 1'b0);
        run_batch(5'd11, 0,  45, 39, 1'b0);
        run_batch(s2d_pkg::t_len'($urandom_range(0, 31)), 36, 36, 39, 1'b0);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_chars.size() != 0) begin
            note_error($sformatf("%0d characters never arrived", expected_chars.size()));
        end
        $display("converted %0d numbers into %0d characters (%0d cut short)",
                 numbers_done, chars_done, truncated_numbers);
        $display("across %0d length-limit writes, with idle, stall and long-hold phases",
                 cfg_writes);
        if (error_count == 0) begin
            $display("signed_int_to_decimal_ascii: match");
        end else begin
            $display("signed_int_to_decimal_ascii: mismatch");
        end
        $finish;
    end

endmodule
